### rtl/pool_slot_allocator_core_assert.svh
// ----------------------------------------------------------------------------
// pool_slot_allocator_core_assert.svh
// assertion macros used by psa_datapath
// ----------------------------------------------------------------------------
`ifndef POOL_SLOT_ALLOCATOR_CORE_ASSERT_SVH
`define POOL_SLOT_ALLOCATOR_CORE_ASSERT_SVH

// condition holds on every clock outside reset
`define PSA_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence holds in the same cycle as the trigger
`define PSA_ASSERT_SAME(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error(msg);

// consequence holds in the cycle after the trigger
`define PSA_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error(msg);

`endif

### rtl/psa_pkg.sv
// ----------------------------------------------------------------------------
// psa_pkg
// shared types and codes of the pool slot allocator
// ----------------------------------------------------------------------------
`default_nettype none

package psa_pkg;

  // fixed field widths
  localparam int POOL_W = 7;
  localparam int SLOT_W = 6;
  localparam int CFG_INDEX_W = 2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_POOL_SIZE     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NOTIFY_ENABLE = 2'd1;

  // request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
  localparam logic [1:0] STATUS_INVALID   = 2'd2;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } psa_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic commit;
  } psa_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
  } psa_stat_t;

endpackage

`default_nettype wire

### rtl/pool_slot_allocator_core.sv
// ----------------------------------------------------------------------------
// pool_slot_allocator_core
// fixed pool of equal-size slots with next-fit allocation
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel: s_tuser is the opcode (allocate or
// free), s_tdata carries the slot to free. Each request yields exactly one
// result on m_axis: m_tuser carries status and the all-free notice, m_tdata
// the granted slot and the free count after the request.
// The accept step registers the eligible-slot vectors and per-byte group
// flags of the rotated search; the commit step that follows picks the first
// group and bit, updates the pool and loads the result register. One
// request is in flight at a time, so a new request is accepted only after
// the current one has committed.
// The result register separates the sides: a new request is accepted while
// an earlier result waits; if m_tready stays low, the following request
// waits in the commit step until the result register frees up.
// The cfg channel writes pool_size (index 0, clears the pool) and
// notify_enable (index 1); it is always ready and must only be used when
// no request is in flight. Reset frees every slot, zeroes the search
// pointer, sets the pool size to 64 (capped at SLOTS) and disables notices.
// ----------------------------------------------------------------------------
`default_nettype none

module pool_slot_allocator_core #(
  parameter int SLOTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [6:0]  cfg_data,
  // requests
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [5:0] slot_index, [7:6] zero
  input  wire logic        s_tuser,   // [0] opcode
  // results
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [5:0] granted_slot, [12:6] free_count, [15:13] zero
  output logic [2:0]       m_tuser    // [1:0] status, [2] all_free_notice
);

  psa_pkg::psa_cmd_t  cmd;
  psa_pkg::psa_stat_t stat;

  logic [1:0]                  res_status;
  logic [psa_pkg::SLOT_W-1:0]  res_granted;
  logic [psa_pkg::POOL_W-1:0]  res_free_count;
  logic                        res_notice;

  assign cfg_ready = 1'b1;

  // sequencer
  psa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_tvalid),
    .req_ready (s_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // pool state and search
  psa_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .req_opcode     (s_tuser),
    .req_slot       (s_tdata[psa_pkg::SLOT_W-1:0]),
    .cmd            (cmd),
    .stat           (stat),
    .res_valid      (m_tvalid),
    .res_ready      (m_tready),
    .res_status     (res_status),
    .res_granted    (res_granted),
    .res_free_count (res_free_count),
    .res_notice     (res_notice)
  );

  // result packing
  assign m_tdata = {3'b000, res_free_count, res_granted};
  assign m_tuser = {res_notice, res_status};

endmodule

`default_nettype wire

### rtl/psa_ctrl.sv
// ----------------------------------------------------------------------------
// psa_ctrl
// request sequencer: capture a request, then commit it into the output slot
// ----------------------------------------------------------------------------
`default_nettype none

module psa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire psa_pkg::psa_stat_t stat,
  output psa_pkg::psa_cmd_t      cmd
);

  psa_pkg::psa_state_t state;
  psa_pkg::psa_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next  = state;
    req_ready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    case (state)
      psa_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = psa_pkg::ST_EXEC;
        end
      end
      psa_pkg::ST_EXEC: begin
        // wait until the result register can take the new result
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = psa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = psa_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/psa_datapath.sv
// ----------------------------------------------------------------------------
// psa_datapath
// occupancy bits, search pointer, free count, rotated free-slot search and
// result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "pool_slot_allocator_core_assert.svh"

module psa_datapath #(
  parameter int SLOTS = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // configuration
  input  wire logic                                cfg_write,
  input  wire logic [psa_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [psa_pkg::POOL_W-1:0]          cfg_data,
  // request payload
  input  wire logic                                req_opcode,
  input  wire logic [psa_pkg::SLOT_W-1:0]          req_slot,
  // control
  input  wire psa_pkg::psa_cmd_t                   cmd,
  output psa_pkg::psa_stat_t                       stat,
  // result
  output logic                                     res_valid,
  input  wire logic                                res_ready,
  output logic [1:0]                               res_status,
  output logic [psa_pkg::SLOT_W-1:0]               res_granted,
  output logic [psa_pkg::POOL_W-1:0]               res_free_count,
  output logic                                     res_notice
);

  localparam int IW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int GROUPS = (SLOTS + 7) / 8;
  localparam int PADW   = GROUPS * 8;
  localparam int XW     = (IW > psa_pkg::SLOT_W) ? IW : psa_pkg::SLOT_W;
  localparam logic [psa_pkg::POOL_W-1:0] RESET_POOL =
    (SLOTS < 64) ? psa_pkg::POOL_W'(SLOTS) : psa_pkg::POOL_W'(64);

  // architectural state
  logic [SLOTS-1:0]              occ;
  logic [psa_pkg::POOL_W-1:0]    ptr;
  logic [psa_pkg::POOL_W-1:0]    free_cnt;
  logic [psa_pkg::POOL_W-1:0]    pool;
  logic                          notify;

  // captured request and first search stage
  logic                          op_q;
  logic [psa_pkg::SLOT_W-1:0]    slot_q;
  logic [PADW-1:0]               vec_hi_q;
  logic [PADW-1:0]               vec_lo_q;
  logic [GROUPS-1:0]             grp_hi_q;
  logic [GROUPS-1:0]             grp_lo_q;

  // search stage one: eligible slots at or above the pointer, and anywhere
  logic [PADW-1:0]               vec_hi;
  logic [PADW-1:0]               vec_lo;
  logic [GROUPS-1:0]             grp_hi;
  logic [GROUPS-1:0]             grp_lo;

  always_comb begin
    vec_hi = '0;
    vec_lo = '0;
    for (int i = 0; i < SLOTS; i++) begin
      vec_lo[i] = !occ[i] && (i < int'(pool));
      vec_hi[i] = vec_lo[i] && (i >= int'(ptr));
    end
    for (int g = 0; g < GROUPS; g++) begin
      grp_hi[g] = |vec_hi[g*8 +: 8];
      grp_lo[g] = |vec_lo[g*8 +: 8];
    end
  end

  // search stage two: first group, then first bit inside it
  int          hi_g;
  int          lo_g;
  int          sel_g;
  int          sel_b;
  int          gi;
  logic [7:0]  sel_vec;
  logic        found;
  logic [psa_pkg::POOL_W-1:0] ptr_alloc;

  always_comb begin
    hi_g = 0;
    lo_g = 0;
    for (int g = GROUPS - 1; g >= 0; g--) begin
      if (grp_hi_q[g]) begin
        hi_g = g;
      end
      if (grp_lo_q[g]) begin
        lo_g = g;
      end
    end
    found   = |grp_hi_q || |grp_lo_q;
    sel_g   = (|grp_hi_q) ? hi_g : lo_g;
    sel_vec = (|grp_hi_q) ? vec_hi_q[hi_g*8 +: 8] : vec_lo_q[lo_g*8 +: 8];
    sel_b   = 0;
    for (int b = 7; b >= 0; b--) begin
      if (sel_vec[b]) begin
        sel_b = b;
      end
    end
    gi = sel_g * 8 + sel_b;
    // pointer moves past the granted slot, wrapping at the pool size
    ptr_alloc = ((gi + 1) >= int'(pool)) ? '0 : psa_pkg::POOL_W'(gi + 1);
  end

  // free request checks
  logic [XW-1:0] slot_x;
  logic          free_ok;
  logic          all_free;

  always_comb begin
    slot_x   = XW'(slot_q);
    free_ok  = (psa_pkg::POOL_W'(slot_q) < pool) && (int'(slot_q) < SLOTS) &&
               occ[slot_x[IW-1:0]];
    all_free = notify && ((free_cnt + psa_pkg::POOL_W'(1)) == pool);
  end

  assign stat.out_free = !res_valid || res_ready;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q     <= req_opcode;
      slot_q   <= req_slot;
      vec_hi_q <= vec_hi;
      vec_lo_q <= vec_lo;
      grp_hi_q <= grp_hi;
      grp_lo_q <= grp_lo;
    end
  end

  // pool state update
  always_ff @(posedge clk) begin
    if (rst) begin
      occ      <= '0;
      ptr      <= '0;
      pool     <= RESET_POOL;
      free_cnt <= RESET_POOL;
      notify   <= 1'b0;
    end else if (cfg_write) begin
      if (cfg_index == psa_pkg::REG_POOL_SIZE) begin
        // a new pool size clears the pool, saturating at the slot count
        occ <= '0;
        ptr <= '0;
        if (int'(cfg_data) > SLOTS) begin
          pool     <= psa_pkg::POOL_W'(SLOTS);
          free_cnt <= psa_pkg::POOL_W'(SLOTS);
        end else begin
          pool     <= cfg_data;
          free_cnt <= cfg_data;
        end
      end else if (cfg_index == psa_pkg::REG_NOTIFY_ENABLE) begin
        notify <= cfg_data[0];
      end
    end else if (cmd.commit) begin
      if (op_q == psa_pkg::OP_ALLOC) begin
        if (found) begin
          occ[IW'(gi)] <= 1'b1;
          free_cnt     <= free_cnt - psa_pkg::POOL_W'(1);
          ptr          <= ptr_alloc;
        end
      end else if (free_ok) begin
        occ[slot_x[IW-1:0]] <= 1'b0;
        ptr                 <= psa_pkg::POOL_W'(slot_q);
        free_cnt            <= free_cnt + psa_pkg::POOL_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.commit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (op_q == psa_pkg::OP_ALLOC) begin
        res_notice <= 1'b0;
        if (found) begin
          res_status     <= psa_pkg::STATUS_OK;
          res_granted    <= psa_pkg::SLOT_W'(gi);
          res_free_count <= free_cnt - psa_pkg::POOL_W'(1);
        end else begin
          res_status     <= psa_pkg::STATUS_EXHAUSTED;
          res_granted    <= '0;
          res_free_count <= free_cnt;
        end
      end else begin
        res_granted <= '0;
        if (free_ok) begin
          res_status     <= psa_pkg::STATUS_OK;
          res_free_count <= free_cnt + psa_pkg::POOL_W'(1);
          res_notice     <= all_free;
        end else begin
          res_status     <= psa_pkg::STATUS_INVALID;
          res_free_count <= free_cnt;
          res_notice     <= 1'b0;
        end
      end
    end
  end

  // checks
  `PSA_ASSERT_ALWAYS(a_free_le_pool, free_cnt <= pool, "free count above pool size")
  `PSA_ASSERT_SAME(a_commit_room, cmd.commit, stat.out_free, "commit with result slot busy")
  `PSA_ASSERT_NEXT(a_commit_shows, cmd.commit, res_valid, "committed result not presented")
  `PSA_ASSERT_NEXT(a_bad_free_holds, cmd.commit && op_q == psa_pkg::OP_FREE && !free_ok, $stable(free_cnt) && $stable(occ), "invalid free changed state")

endmodule

`default_nettype wire
